// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam logic [7:0]  MARK_START = 8'h01;
    localparam logic [7:0]  MARK_END   = 8'h04;
    localparam logic [7:0]  MARK_ESC   = 8'h10;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // class of one unescaped word handed from front to back
    typedef enum logic [1:0] {
        CLS_DATA  = 2'd0,
        CLS_START = 2'd1,
        CLS_END   = 2'd2
    } item_cls_t;

    typedef struct packed {
        item_cls_t  cls;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfr_front.sv =====
module sfr_front
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  q_status_t  q_status,
    output logic       push,
    output item_t      push_item
);

    logic escape_reg;
    logic escape_next;
    logic accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        escape_next    = escape_reg;
        push           = 1'b0;
        push_item.cls  = CLS_DATA;
        push_item.data = rx_byte;
        if (accept)
        begin
            if (escape_reg)
            begin
                escape_next = 1'b0;
                push        = 1'b1;
            end
            else
            begin
                unique case (rx_byte)
                    MARK_ESC:
                    begin
                        escape_next = 1'b1;
                    end
                    MARK_START:
                    begin
                        push          = 1'b1;
                        push_item.cls = CLS_START;
                    end
                    MARK_END:
                    begin
                        push          = 1'b1;
                        push_item.cls = CLS_END;
                    end
                    default:
                    begin
                        push = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
        end
    end

endmodule

// ===== rtl/sfr_queue.sv =====
module sfr_queue
    import sfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head,
    output q_status_t status
);

    localparam int DEPTH = 2;

    item_t      mem [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'(DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sfr_back.sv =====
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  item_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic       frame_good,
    output logic [5:0] payload_length,
    output logic       frame_overflow
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    hold0_reg, hold0_next;
    logic [7:0]    hold1_reg, hold1_next;
    logic [15:0]   crc_reg, crc_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [7:0]    byte_reg, byte_next;
    logic          good_reg, good_next;
    logic [5:0]    len_reg, len_next;
    logic          oflag_reg, oflag_next;
    logic [CW+5:0] len_wide;

    assign pop      = !q_status.empty && (!out_valid_reg || out_ready);
    assign len_wide = {6'd0, count_reg} - (CW + 6)'(2);

    always_comb
    begin
        count_next     = count_reg;
        hold0_next     = hold0_reg;
        hold1_next     = hold1_reg;
        crc_next       = crc_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        good_next      = good_reg;
        len_next       = len_reg;
        oflag_next     = oflag_reg;
        if (pop)
        begin
            unique case (head.cls)
                CLS_START:
                begin
                    count_next = '0;
                    hold0_next = 8'd0;
                    hold1_next = 8'd0;
                    crc_next   = 16'd0;
                    ovf_next   = 1'b0;
                end
                CLS_END:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    byte_next      = 8'd0;
                    oflag_next     = ovf_reg;
                    // received CRC sits in the hold line, low byte first
                    if (!ovf_reg && count_reg >= CW'(3) && {hold1_reg, hold0_reg} == crc_reg)
                    begin
                        good_next = 1'b1;
                        len_next  = len_wide[5:0];
                    end
                    else
                    begin
                        good_next = 1'b0;
                        len_next  = 6'd0;
                    end
                    count_next = '0;
                    hold0_next = 8'd0;
                    hold1_next = 8'd0;
                    crc_next   = 16'd0;
                    ovf_next   = 1'b0;
                end
                CLS_DATA:
                begin
                    if (count_reg >= MAX_CNT)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg >= CW'(2))
                        begin
                            crc_next       = crc_byte(crc_reg, hold0_reg);
                            out_valid_next = 1'b1;
                            kind_next      = 1'b0;
                            byte_next      = hold0_reg;
                            good_next      = 1'b0;
                            len_next       = 6'd0;
                            oflag_next     = 1'b0;
                        end
                        hold0_next = hold1_reg;
                        hold1_next = head.data;
                        count_next = count_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hold0_reg     <= 8'd0;
            hold1_reg     <= 8'd0;
            crc_reg       <= 16'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            hold0_reg     <= hold0_next;
            hold1_reg     <= hold1_next;
            crc_reg       <= crc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        good_reg  <= good_next;
        len_reg   <= len_next;
        oflag_reg <= oflag_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign payload_byte   = byte_reg;
    assign frame_good     = good_reg;
    assign payload_length = len_reg;
    assign frame_overflow = oflag_reg;

endmodule

// ===== rtl/stuffed_frame_receiver_crc16_top.sv =====
// An accepted word is registered in the queue, then its result (if any) at out_valid.
// Throughput: one word per cycle unless stalled; back folds one byte into the CRC per cycle.
// A two-entry queue between front and back absorbs up to two words while a result stalls.
// Reset (rst_n, async, active low) clears escape, queue, frame count, hold line, CRC,
// overflow flag and the output valid; no clearing pass is needed.
module stuffed_frame_receiver_crc16_top
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic       frame_good,
    output logic [5:0] payload_length,
    output logic       frame_overflow
);

    // front: escape tracking and mark detection, one word per cycle while the queue has room
    logic      push;
    item_t     push_item;
    // queue decouples the stall of the output from the input side
    logic      pop;
    item_t     head;
    q_status_t q_status;

    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // back: hold line, frame count, running CRC and the output register
    sfr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .frame_good     (frame_good),
        .payload_length (payload_length),
        .frame_overflow (frame_overflow)
    );

endmodule
